// ----- src/h264wp_pkg.sv -----
package h264wp_pkg;

  // Field widths.
  localparam int unsigned PixW     = 8;
  localparam int unsigned WeightW  = 9;
  localparam int unsigned OffsetW  = 8;
  localparam int unsigned Log2W    = 3;
  localparam int unsigned ShamtW   = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 9;

  // Internal arithmetic widths.
  // A product of an unsigned pixel and a signed weight.
  localparam int unsigned ProdW = PixW + 1 + WeightW;
  // The largest offset term is 129 << 7; only the unidirectional term adds the rounding constant.
  localparam int unsigned AddW  = 17;
  // Two products plus the offset term.
  localparam int unsigned SumW  = ProdW + 2;

  // Largest value of a clipped pixel.
  localparam int unsigned PixMax = 255;

  // Register reset values.
  localparam logic                      ModeRst   = 1'b0;
  localparam logic [Log2W-1:0]          Log2Rst   = '0;
  localparam logic signed [WeightW-1:0] WeightRst = 9'sd1;
  localparam logic signed [OffsetW-1:0] OffsetRst = '0;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE       = 3'd0,
    CFG_LOG2_DENOM = 3'd1,
    CFG_WEIGHT_UNI = 3'd2,
    CFG_WEIGHT_DST = 3'd3,
    CFG_WEIGHT_SRC = 3'd4,
    CFG_OFFSET     = 3'd5
  } cfg_idx_e;

  // One input transaction: four first-reference and four second-reference pixels.
  typedef struct packed {
    logic [PixW-1:0] dst_pixel_0;
    logic [PixW-1:0] dst_pixel_1;
    logic [PixW-1:0] dst_pixel_2;
    logic [PixW-1:0] dst_pixel_3;
    logic [PixW-1:0] src_pixel_0;
    logic [PixW-1:0] src_pixel_1;
    logic [PixW-1:0] src_pixel_2;
    logic [PixW-1:0] src_pixel_3;
  } pix_in_t;

  // One result transaction: four weighted pixels.
  typedef struct packed {
    logic [PixW-1:0] out_pixel_0;
    logic [PixW-1:0] out_pixel_1;
    logic [PixW-1:0] out_pixel_2;
    logic [PixW-1:0] out_pixel_3;
  } pix_out_t;

  // Per-lane controls, derived once from the configuration registers.
  typedef struct packed {
    logic                      use_src;
    logic signed [WeightW-1:0] weight_a;
    logic signed [WeightW-1:0] weight_b;
    logic signed [AddW-1:0]    add_term;
    logic [ShamtW-1:0]         shamt;
  } lane_cfg_t;

endpackage

// ----- src/h264_weighted_prediction_8bit_top.sv -----
// H.264 explicit weighted prediction for 8-bit pixels, four lanes per transaction.
//
// Input channel: drive req_i and raise start_i; the transaction is taken at a rising
// edge where start_i is high and busy_o is low. busy_o stays low, so a new group of
// four pixels may be started in every cycle.
// Result channel: done_o is high for exactly one cycle with result_o holding the four
// weighted pixels. Results appear in order.
// The receiver cannot stall, so the pipeline never holds and simply advances.
// Throughput is one transaction per cycle; latency is set by the three register
// stages of each lane: multiply, sum, then shift and clip.
// Configuration: write cfg_data_i to register cfg_index_i with cfg_valid_i; cfg_ready_o
// is always high. Index 0 mode, 1 log2 denominator, 2 to 4 weights, 5 offset; other
// indexes are ignored. Write only while no transaction is in flight.
// Reset: rst_ni is asynchronous and active low. It empties the pipeline and returns
// the registers to mode 0, denominator 0, all weights 1 and offset 0.
module h264_weighted_prediction_8bit_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  h264wp_pkg::pix_in_t             req_i,
  output logic                            done_o,
  output h264wp_pkg::pix_out_t            result_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [h264wp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [h264wp_pkg::CfgDataW-1:0] cfg_data_i
);
  import h264wp_pkg::*;

  localparam int unsigned Lanes  = 4;
  localparam int unsigned Stages = 3;

  logic                      mode_q;
  logic [Log2W-1:0]          log2_denom_q;
  logic signed [WeightW-1:0] weight_uni_q, weight_dst_q, weight_src_q;
  logic signed [OffsetW-1:0] offset_q;
  logic                      cfg_write;
  logic                      accept;
  logic [Stages-1:0]         valid_d, valid_q;
  logic signed [WeightW-1:0] bi_offset;
  logic signed [AddW-1:0]    round_term;
  lane_cfg_t                 lane_cfg;
  logic [PixW-1:0]           dst_pix [Lanes];
  logic [PixW-1:0]           src_pix [Lanes];
  logic [PixW-1:0]           out_pix [Lanes];

  // The pipeline never holds, so the input side is always free.
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeRst;
      log2_denom_q <= Log2Rst;
      weight_uni_q <= WeightRst;
      weight_dst_q <= WeightRst;
      weight_src_q <= WeightRst;
      offset_q     <= OffsetRst;
    end else if (cfg_write) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MODE:       mode_q       <= cfg_data_i[0];
        CFG_LOG2_DENOM: log2_denom_q <= cfg_data_i[Log2W-1:0];
        CFG_WEIGHT_UNI: weight_uni_q <= $signed(cfg_data_i[WeightW-1:0]);
        CFG_WEIGHT_DST: weight_dst_q <= $signed(cfg_data_i[WeightW-1:0]);
        CFG_WEIGHT_SRC: weight_src_q <= $signed(cfg_data_i[WeightW-1:0]);
        CFG_OFFSET:     offset_q     <= $signed(cfg_data_i[OffsetW-1:0]);
        default: ;
      endcase
    end
  end

  // Shared lane controls: weight choice, offset term and shift amount.
  // In bidirectional mode the offset becomes ((offset + 1) | 1), shifted up by L.
  assign bi_offset = (WeightW'(offset_q) + 9'sd1) | 9'sd1;

  always_comb begin
    if (log2_denom_q != '0) begin
      round_term = AddW'(1) << (log2_denom_q - Log2W'(1));
    end else begin
      round_term = '0;
    end
  end

  always_comb begin
    lane_cfg.use_src = mode_q;
    if (mode_q) begin
      lane_cfg.weight_a = weight_dst_q;
      lane_cfg.weight_b = weight_src_q;
      lane_cfg.add_term = AddW'(bi_offset) <<< log2_denom_q;
      lane_cfg.shamt    = ShamtW'(log2_denom_q) + ShamtW'(1);
    end else begin
      lane_cfg.weight_a = weight_uni_q;
      lane_cfg.weight_b = weight_src_q;
      lane_cfg.add_term = (AddW'(offset_q) <<< log2_denom_q) + round_term;
      lane_cfg.shamt    = ShamtW'(log2_denom_q);
    end
  end

  // Unpack the lanes.
  assign dst_pix[0] = req_i.dst_pixel_0;
  assign dst_pix[1] = req_i.dst_pixel_1;
  assign dst_pix[2] = req_i.dst_pixel_2;
  assign dst_pix[3] = req_i.dst_pixel_3;
  assign src_pix[0] = req_i.src_pixel_0;
  assign src_pix[1] = req_i.src_pixel_1;
  assign src_pix[2] = req_i.src_pixel_2;
  assign src_pix[3] = req_i.src_pixel_3;

  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    h264wp_lane u_lane (
      .clk_i (clk_i),
      .cfg_i (lane_cfg),
      .dst_i (dst_pix[g]),
      .src_i (src_pix[g]),
      .pix_o (out_pix[g])
    );
  end

  // Valid bits travel alongside the lane stages.
  assign valid_d = {valid_q[Stages-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign done_o               = valid_q[Stages-1];
  assign result_o.out_pixel_0 = out_pix[0];
  assign result_o.out_pixel_1 = out_pix[1];
  assign result_o.out_pixel_2 = out_pix[2];
  assign result_o.out_pixel_3 = out_pix[3];

  // Every accepted transaction produces a result on done_o.
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 done_o)
    else $error("accepted transaction did not complete in three cycles");

  // No result appears without a matching accepted transaction.
  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 3))
    else $error("result strobe without an accepted transaction");

  // A mode write takes effect at the next edge.
  a_mode_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_write && cfg_index_i == CFG_MODE) |=> (mode_q == $past(cfg_data_i[0])))
    else $error("mode register did not take the written value");

endmodule

// ----- src/h264wp_lane.sv -----
module h264wp_lane (
  input  logic                      clk_i,
  input  h264wp_pkg::lane_cfg_t     cfg_i,
  input  logic [h264wp_pkg::PixW-1:0] dst_i,
  input  logic [h264wp_pkg::PixW-1:0] src_i,
  output logic [h264wp_pkg::PixW-1:0] pix_o
);
  import h264wp_pkg::*;

  logic signed [ProdW-1:0] prod_a_d, prod_a_q;
  logic signed [ProdW-1:0] prod_b_d, prod_b_q;
  logic signed [SumW-1:0]  sum_d, sum_q;
  logic signed [SumW-1:0]  shifted;
  logic [PixW-1:0]         pix_d, pix_q;

  // Stage 1: the two weight multiplications.
  always_comb begin
    prod_a_d = ProdW'($signed({1'b0, dst_i}) * cfg_i.weight_a);
    if (cfg_i.use_src) begin
      prod_b_d = ProdW'($signed({1'b0, src_i}) * cfg_i.weight_b);
    end else begin
      prod_b_d = '0;
    end
  end

  // Stage 2: sum of the products and the offset term.
  assign sum_d = SumW'(prod_a_q) + SumW'(prod_b_q) + SumW'(cfg_i.add_term);

  // Stage 3: floor shift and clip to the pixel range.
  assign shifted = sum_q >>> cfg_i.shamt;

  always_comb begin
    if (shifted < 0) begin
      pix_d = '0;
    end else if (shifted > $signed(SumW'(PixMax))) begin
      pix_d = PixW'(PixMax);
    end else begin
      pix_d = shifted[PixW-1:0];
    end
  end

  // Datapath registers; validity is tracked by the top level.
  always_ff @(posedge clk_i) begin
    prod_a_q <= prod_a_d;
    prod_b_q <= prod_b_d;
    sum_q    <= sum_d;
    pix_q    <= pix_d;
  end

  assign pix_o = pix_q;

endmodule

// ----- test/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import h264wp_pkg::*;

  // Mode register values.
  localparam logic ModeUni = 1'b0;
  localparam logic ModeBi  = 1'b1;

  // Register indexes that lie beyond the register list; writes to them are dropped.
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;

  // Three register stages per lane; a little margin on top of that when draining.
  localparam int PipeDepth     = 3;
  localparam int DrainPad      = PipeDepth + 3;
  localparam int WatchdogLimit = 2000;
  localparam int ItemTarget    = 1050;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start_i     = 1'b0;
  logic                busy_o;
  pix_in_t             req_i       = '0;
  logic                done_o;
  pix_out_t            result_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // Our own copy of the weighting registers, updated on each accepted write.
  logic                      cur_mode       = ModeRst;
  logic [Log2W-1:0]          cur_log2       = Log2Rst;
  logic signed [WeightW-1:0] cur_weight_uni = WeightRst;
  logic signed [WeightW-1:0] cur_weight_dst = WeightRst;
  logic signed [WeightW-1:0] cur_weight_src = WeightRst;
  logic signed [OffsetW-1:0] cur_offset     = OffsetRst;

  pix_in_t  pending_groups[$];
  pix_out_t expected_groups[$];

  int queued_cnt   = 0;
  int accepted_cnt = 0;
  int checked_cnt  = 0;
  int uni_cnt      = 0;
  int bi_cnt       = 0;
  int cfg_cnt      = 0;
  int setting_cnt  = 0;
  int mismatches   = 0;
  int gap_left     = 0;
  int quiet_cycles = 0;

  h264_weighted_prediction_8bit_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Clip an exact sum to the 8-bit pixel range.
  function automatic logic [PixW-1:0] clip_pixel(int v);
    if (v < 0) begin
      return '0;
    end
    if (v > int'(PixMax)) begin
      return PixW'(PixMax);
    end
    return v[PixW-1:0];
  endfunction

  // Weighted prediction of one four-lane group under the current registers.
  function automatic pix_out_t weigh_pixels(pix_in_t px);
    pix_out_t weighed;
    int       acc;
    int       round_add;
    int       odd_offset;
    int       dst_pix;
    int       src_pix;
    weighed    = '0;
    round_add  = (cur_log2 == 0) ? 0 : (1 << (cur_log2 - 1));
    // Bidirectional offset term is always odd: (offset + 1) | 1.
    odd_offset = (int'(cur_offset) + 1) | 1;
    for (int i = 0; i < 4; i++) begin
      dst_pix = int'(px[(7 - i) * PixW +: PixW]);
      src_pix = int'(px[(3 - i) * PixW +: PixW]);
      if (cur_mode == ModeUni) begin
        acc = dst_pix * int'(cur_weight_uni) + int'(cur_offset) * (1 << cur_log2) + round_add;
        acc = acc >>> cur_log2;
      end else begin
        acc = dst_pix * int'(cur_weight_dst) + src_pix * int'(cur_weight_src)
            + odd_offset * (1 << cur_log2);
        acc = acc >>> (cur_log2 + 1);
      end
      weighed[(3 - i) * PixW +: PixW] = clip_pixel(acc);
    end
    return weighed;
  endfunction

  // Pixels lean toward the extremes now and then.
  function automatic logic [PixW-1:0] rand_pixel();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      return '0;
    end
    if (roll < 20) begin
      return '1;
    end
    return PixW'($urandom);
  endfunction

  // Mostly weights near unity or in the legal range, sometimes any 9-bit value.
  function automatic logic [WeightW-1:0] pick_weight(logic [Log2W-1:0] l2);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) begin
      return WeightW'((1 << l2) + int'($urandom_range(0, 30)) - 15);
    end
    if (roll < 8) begin
      return WeightW'(int'($urandom_range(0, 256)) - 128);
    end
    return WeightW'($urandom);
  endfunction

  // Input driver: holds each group until the block takes it, then idles at random.
  always @(posedge clk_i or negedge rst_ni) begin : drive_groups
    int roll;
    if (!rst_ni) begin
      start_i  <= 1'b0;
      req_i    <= '0;
      gap_left <= 0;
    end else begin
      if (start_i && !busy_o) begin
        expected_groups.push_back(weigh_pixels(req_i));
        if (cur_mode == ModeBi) begin
          bi_cnt++;
        end else begin
          uni_cnt++;
        end
        accepted_cnt++;
      end
      if (!start_i || !busy_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start_i  <= 1'b0;
        end else if (pending_groups.size() != 0) begin
          req_i   <= pending_groups.pop_front();
          start_i <= 1'b1;
          roll    = $urandom_range(0, 99);
          if (roll < 55) begin
            gap_left <= 0;
          end else if (roll < 93) begin
            gap_left <= $urandom_range(1, 3);
          end else begin
            gap_left <= $urandom_range(8, 40);
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every strobed result is compared lane by lane with the oldest prediction.
  always @(posedge clk_i) begin : check_groups
    pix_out_t want;
    if (rst_ni && done_o) begin
      if (expected_groups.size() == 0) begin
        $display("%0t: unexpected result %h with no transaction outstanding",
                 $realtime, result_o);
        mismatches++;
      end else begin
        want = expected_groups.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (result_o[(3 - i) * PixW +: PixW] !== want[(3 - i) * PixW +: PixW]) begin
            $display("%0t: out_pixel_%0d expected %0d, actual %0d", $realtime, i,
                     want[(3 - i) * PixW +: PixW], result_o[(3 - i) * PixW +: PixW]);
            mismatches++;
          end
        end
        checked_cnt++;
      end
    end
  end

  // Watchdog: ends the run if no transaction moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: timeout, no transaction for %0d cycles", $realtime, WatchdogLimit);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One register write; our register copy follows the accepted transaction.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MODE:       cur_mode       <= data[0];
      CFG_LOG2_DENOM: cur_log2       <= data[Log2W-1:0];
      CFG_WEIGHT_UNI: cur_weight_uni <= data;
      CFG_WEIGHT_DST: cur_weight_dst <= data;
      CFG_WEIGHT_SRC: cur_weight_src <= data;
      CFG_OFFSET:     cur_offset     <= data[OffsetW-1:0];
      default: ;
    endcase
    cfg_cnt++;
  endtask

  // Writes all six registers; unused upper data bits carry random junk.
  task automatic apply_setting(logic mode_v, logic [Log2W-1:0] l2, logic [WeightW-1:0] wu,
                               logic [WeightW-1:0] wd, logic [WeightW-1:0] ws,
                               logic [OffsetW-1:0] off);
    write_reg(CFG_MODE, {8'($urandom), mode_v});
    write_reg(CFG_LOG2_DENOM, {6'($urandom), l2});
    write_reg(CFG_WEIGHT_UNI, wu);
    write_reg(CFG_WEIGHT_DST, wd);
    write_reg(CFG_WEIGHT_SRC, ws);
    write_reg(CFG_OFFSET, {1'($urandom), off});
    setting_cnt++;
  endtask

  task automatic queue_group(pix_in_t grp);
    pending_groups.push_back(grp);
    queued_cnt++;
  endtask

  // Waits until every queued group has been taken and its result checked, then lets
  // the pipeline settle before the registers change.
  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || checked_cnt != accepted_cnt) begin
      @(posedge clk_i);
    end
    repeat (DrainPad) @(posedge clk_i);
  endtask

  initial begin
    pix_in_t          grp;
    int               n_items;
    logic [Log2W-1:0] l2;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values give the identity setting; src pixels must have no effect.
    setting_cnt++;
    queue_group(pix_in_t'{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    queue_group(pix_in_t'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
    queue_group(pix_in_t'{8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'h33, 8'hCC});
    queue_group(pix_in_t'{8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55});
    wait_idle();

    // Writes past the register list must leave the identity setting in place.
    write_reg(CfgIdxSpareLo, '1);
    write_reg(CfgIdxSpareHi, 9'h0AA);
    queue_group(pix_in_t'{8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE, 8'hF0});
    wait_idle();

    // Unidirectional, largest denominator, weight 128 and the largest offset.
    apply_setting(ModeUni, 3'd7, 9'd128, 9'd1, 9'd1, 8'sd127);
    queue_group(pix_in_t'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    queue_group(pix_in_t'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    queue_group(pix_in_t'{8'h01, 8'h40, 8'h81, 8'hC0, 8'h12, 8'h34, 8'h56, 8'h78});
    wait_idle();

    // Unidirectional, no denominator, most negative weight and offset.
    apply_setting(ModeUni, 3'd0, 9'h180, 9'd1, 9'd1, 8'h80);
    queue_group(pix_in_t'{8'h00, 8'h01, 8'h02, 8'h03, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    queue_group(pix_in_t'{8'hFF, 8'hFE, 8'h80, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00});
    wait_idle();

    // Weight outside the legal range is used as the raw 9-bit value.
    apply_setting(ModeUni, 3'd3, 9'h100, 9'd1, 9'd1, 8'sd0);
    queue_group(pix_in_t'{8'h00, 8'h10, 8'h80, 8'hFF, 8'h5A, 8'hA5, 8'h5A, 8'hA5});
    queue_group(pix_in_t'{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80});
    wait_idle();

    // Bidirectional, no denominator, weights at both legal extremes.
    apply_setting(ModeBi, 3'd0, 9'd1, 9'd128, 9'h180, 8'h80);
    queue_group(pix_in_t'{8'hFF, 8'hFF, 8'h00, 8'h80, 8'h00, 8'hFF, 8'h00, 8'h7F});
    queue_group(pix_in_t'{8'h00, 8'h00, 8'hFF, 8'h01, 8'hFF, 8'h00, 8'hFF, 8'hFE});
    queue_group(pix_in_t'{8'h40, 8'h41, 8'h42, 8'h43, 8'h3F, 8'h3E, 8'h3D, 8'h3C});
    wait_idle();

    // Bidirectional, largest denominator, weights outside the legal range.
    apply_setting(ModeBi, 3'd7, 9'd1, 9'h0FF, 9'h100, 8'sd127);
    queue_group(pix_in_t'{8'hFF, 8'h00, 8'hFF, 8'h80, 8'h00, 8'h00, 8'hFF, 8'h80});
    queue_group(pix_in_t'{8'h00, 8'hFF, 8'h11, 8'hEE, 8'hFF, 8'hFF, 8'h22, 8'hDD});
    queue_group(pix_in_t'{8'h7F, 8'h80, 8'h01, 8'hFE, 8'h80, 8'h7F, 8'hFE, 8'h01});
    wait_idle();

    // Bidirectional average with offset -1, where the odd offset term wraps to one.
    apply_setting(ModeBi, 3'd5, 9'd1, 9'd32, 9'd32, 8'hFF);
    queue_group(pix_in_t'{8'h00, 8'h01, 8'hFE, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF});
    queue_group(pix_in_t'{8'h10, 8'h20, 8'h30, 8'h40, 8'h11, 8'h21, 8'h31, 8'h41});
    queue_group(pix_in_t'{8'hC8, 8'h64, 8'h32, 8'h19, 8'h19, 8'h32, 8'h64, 8'hC8});
    wait_idle();

    // Random settings, each followed by a burst of random pixel groups.
    while (queued_cnt < ItemTarget) begin
      l2 = Log2W'($urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0) begin
        l2 = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'd7;
      end
      apply_setting(1'($urandom), l2, pick_weight(l2), pick_weight(l2), pick_weight(l2),
                    OffsetW'($urandom));
      n_items = $urandom_range(8, 40);
      for (int k = 0; k < n_items; k++) begin
        for (int b = 0; b < 8; b++) begin
          grp[b * PixW +: PixW] = rand_pixel();
        end
        queue_group(grp);
      end
      wait_idle();
    end

    repeat (DrainPad) @(posedge clk_i);
    if (expected_groups.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, expected_groups.size());
      mismatches++;
    end
    $display("Run covered %0d pixel groups (%0d unidirectional, %0d bidirectional).",
             accepted_cnt, uni_cnt, bi_cnt);
    $display("%0d register writes across %0d weighting settings; %0d results compared.",
             cfg_cnt, setting_cnt, checked_cnt);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
